FILE: rtl/mbpf_pkg.sv
// shared constants, types and helpers of the masked byte pattern filter
package mbpf_pkg;

  // design constants
  localparam int MAX_PATTERN   = 8;
  localparam int POSITION_BITS = 16;
  localparam int LEN_BITS      = 4;
  localparam int IDX_BITS      = 3;
  localparam int CFG_BITS      = 64;
  localparam int OFFSET_BITS   = 16;
  // width that holds position + 1 and the start offset without loss
  localparam int CMP_BITS      = (POSITION_BITS + 1 > OFFSET_BITS) ?
                                 POSITION_BITS + 1 : OFFSET_BITS;

  typedef logic [7:0]                    byte_t;
  typedef logic [MAX_PATTERN-1:0][7:0]   window_t;
  typedef logic [POSITION_BITS-1:0]      pos_t;
  typedef logic [LEN_BITS-1:0]           len_t;

  // configuration register indexes
  typedef enum logic [IDX_BITS-1:0] {
    REG_PATTERN_BYTES  = 3'd0,
    REG_PATTERN_LENGTH = 3'd1,
    REG_CARE_MASK      = 3'd2,
    REG_START_OFFSET   = 3'd3,
    REG_INVERT_RESULT  = 3'd4
  } reg_idx_t;

  // configuration register file contents
  typedef struct packed {
    logic [CFG_BITS-1:0]    pattern_bytes;
    len_t                   pattern_length;
    logic [7:0]             care_mask;
    logic [OFFSET_BITS-1:0] start_offset;
    logic                   invert_result;
  } cfg_t;

  // pattern length in use: zero reads as one, large values saturate
  function automatic len_t used_length(input len_t len);
    len_t n;
    n = len;
    if (n == '0) n = len_t'(1);
    if (n > len_t'(MAX_PATTERN)) n = len_t'(MAX_PATTERN);
    return n;
  endfunction

endpackage

FILE: rtl/mbpf_cfg_regs.sv
// configuration register file with plain write port
module mbpf_cfg_regs
  import mbpf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0] cfg_wdata,
  output cfg_t                cfg
);

  cfg_t cfg_r;

  // register writes, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_bytes  <= '0;
      cfg_r.pattern_length <= len_t'(1);
      cfg_r.care_mask      <= 8'hFF;
      cfg_r.start_offset   <= '0;
      cfg_r.invert_result  <= 1'b0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PATTERN_BYTES:  cfg_r.pattern_bytes  <= cfg_wdata;
        REG_PATTERN_LENGTH: cfg_r.pattern_length <= cfg_wdata[LEN_BITS-1:0];
        REG_CARE_MASK:      cfg_r.care_mask      <= cfg_wdata[7:0];
        REG_START_OFFSET:   cfg_r.start_offset   <= cfg_wdata[OFFSET_BITS-1:0];
        REG_INVERT_RESULT:  cfg_r.invert_result  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/mbpf_match.sv
// masked window compare and start offset check for one byte
module mbpf_match
  import mbpf_pkg::*;
(
  input  window_t win,
  input  pos_t    pos,
  input  cfg_t    cfg,
  output logic    hit
);

  len_t                  len;
  logic [MAX_PATTERN:1]  len_match;
  logic [CMP_BITS-1:0]   end_cnt;
  logic [CMP_BITS-1:0]   start;
  logic                  full_window;
  logic                  late_enough;

  assign len = used_length(cfg.pattern_length);

  // one masked compare per possible pattern length, fixed byte taps
  always_comb begin
    for (int l = 1; l <= MAX_PATTERN; l++) begin
      len_match[l] = 1'b1;
      for (int i = 0; i < l; i++) begin
        if (cfg.care_mask[i] && (win[l-1-i] != cfg.pattern_bytes[8*i +: 8]))
          len_match[l] = 1'b0;
      end
    end
  end

  // window must lie inside the packet and start at or after the offset
  assign end_cnt     = CMP_BITS'(pos) + CMP_BITS'(1);
  assign full_window = end_cnt >= CMP_BITS'(len);
  assign start       = end_cnt - CMP_BITS'(len);
  assign late_enough = start >= CMP_BITS'(cfg.start_offset);

  assign hit = full_window && late_enough && len_match[len];

endmodule

FILE: rtl/masked_byte_pattern_filter.sv
// top level of the masked byte pattern filter
//
//  channel | direction | transaction            | handshake
//  --------+-----------+------------------------+------------------------
//  in_     | input     | data_byte, last_byte   | in_valid / in_stall
//  out_    | output    | selected               | out_valid / out_stall
//  cfg_    | input     | register index, data   | cfg_we, no wait
//
// one byte per cycle while no last byte waits on a stalled output: an accepted byte
// is captured in the input register, and the window compare and state update run
// from there once it is processed, so the verdict of a last byte lands in the output register.
// reset clears the packet state and both valid flags and loads the configuration defaults.
// a waiting verdict holds only a last byte; other bytes keep flowing.
module masked_byte_pattern_filter
  import mbpf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_data_byte,
  input  logic                in_last_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_selected,
  input  logic                cfg_we,
  input  logic [IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0] cfg_wdata
);

  cfg_t    cfg;
  logic    in_valid_r;
  byte_t   in_data_r;
  logic    in_last_r;
  window_t win_r, win_nxt;
  pos_t    pos_r, pos_nxt;
  logic    seen_r, seen_nxt;
  logic    out_valid_r;
  logic    out_selected_r;
  logic    hit;
  logic    out_free;
  logic    proc_go;
  logic    in_take;

  mbpf_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // handshake control
  assign out_free = !out_valid_r || !out_stall;
  assign proc_go  = in_valid_r && (!in_last_r || out_free);
  assign in_stall = in_valid_r && !proc_go;
  assign in_take  = in_valid && !in_stall;

  // shifted window with the new byte at the newest place
  always_comb begin
    win_nxt[0] = in_data_r;
    for (int k = 1; k < MAX_PATTERN; k++) win_nxt[k] = win_r[k-1];
  end

  mbpf_match u_match (
    .win (win_nxt),
    .pos (pos_r),
    .cfg (cfg),
    .hit (hit)
  );

  assign seen_nxt = seen_r || hit;
  assign pos_nxt  = (pos_r == '1) ? pos_r : pos_r + pos_t'(1);

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (proc_go) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data_byte;
      in_last_r <= in_last_byte;
    end
  end

  // packet state, cleared after the last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r  <= '0;
      pos_r  <= '0;
      seen_r <= 1'b0;
    end else if (proc_go) begin
      if (in_last_r) begin
        win_r  <= '0;
        pos_r  <= '0;
        seen_r <= 1'b0;
      end else begin
        win_r  <= win_nxt;
        pos_r  <= pos_nxt;
        seen_r <= seen_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_go && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && in_last_r) begin
      out_selected_r <= seen_nxt ^ cfg.invert_result;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_selected = out_selected_r;

endmodule
